>>> rtl/pgn_pkg.sv
package pgn_pkg;

    // Input word: one seed or draw command
    typedef struct packed {
        logic               func;
        logic signed [31:0] tile_row;
        logic signed [31:0] tile_col;
    } t_in;

    // Output word: one pair of Q5.26 normals
    typedef struct packed {
        logic signed [31:0] sample_first;
        logic signed [31:0] sample_second;
    } t_out;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SEED1,
        S_SEED2,
        S_LCG,
        S_SQ,
        S_CHECK,
        S_NORM,
        S_ZDIV,
        S_Z2,
        S_PMUL,
        S_PDIV,
        S_LN,
        S_YMUL,
        S_YDIV,
        S_SQRT,
        S_GMUL,
        S_OUT
    } t_state;

    localparam logic       FUNC_SEED  = 1'b0;
    localparam logic       FUNC_DRAW  = 1'b1;
    localparam logic [63:0] LCG_MULT  = 64'd6364136223846793005;
    localparam logic [63:0] LCG_INC   = 64'd1442695040888963407;
    localparam logic [63:0] GOLD      = 64'h0000_0000_9E37_79B9;
    localparam logic [31:0] LN2_HI    = 32'hB172_17F7;
    localparam logic [31:0] LN2_LO    = 32'hD1CF_79AC;
    localparam logic [63:0] SQRT2_Q61 = 64'h2D41_3CCC_FE77_9921;
    localparam logic [31:0] HALF_M1   = 32'h7FFF_FFFF;
    localparam logic [3:0]  N_TERMS   = 4'd12;
    localparam logic [5:0]  TOP_BIT   = 6'd61;

    // XSH-RR output permutation of one LCG state
    function automatic logic [31:0] pgn_perm(input logic [63:0] st);
        logic [63:0] x;
        logic [31:0] x32;
        logic [4:0]  rot;
        logic [63:0] dbl;
        x   = ((st >> 18) ^ st) >> 27;
        x32 = x[31:0];
        rot = st[63:59];
        dbl = {x32, x32} >> rot;
        return dbl[31:0];
    endfunction

    // ceil(2^65 / (2i+1)) for series term i; exact floor division of any
    // term below 2^60 when the product is taken down by 65 bits
    function automatic logic [63:0] pgn_recip(input logic [3:0] i);
        logic [63:0] m;
        unique case (i)
            4'd1:    m = 64'hAAAA_AAAA_AAAA_AAAB;
            4'd2:    m = 64'h6666_6666_6666_6667;
            4'd3:    m = 64'h4924_9249_2492_4925;
            4'd4:    m = 64'h38E3_8E38_E38E_38E4;
            4'd5:    m = 64'h2E8B_A2E8_BA2E_8BA3;
            4'd6:    m = 64'h2762_7627_6276_2763;
            4'd7:    m = 64'h2222_2222_2222_2223;
            4'd8:    m = 64'h1E1E_1E1E_1E1E_1E1F;
            4'd9:    m = 64'h1AF2_86BC_A1AF_286C;
            4'd10:   m = 64'h1861_8618_6186_1862;
            4'd11:   m = 64'h1642_C859_0B21_642D;
            4'd12:   m = 64'h147A_E147_AE14_7AE2;
            default: m = 64'd0;
        endcase
        return m;
    endfunction

endpackage

>>> rtl/pgn_mul.sv
// 64x64 -> 128 multiplier, one 32x32 partial product per cycle
module pgn_mul (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [63:0]   i_a,
    input  logic [63:0]   i_b,
    output logic          o_done,
    output logic [127:0]  o_p
);
    logic [63:0]  r_a, r_b;
    logic [2:0]   r_cnt;
    logic         r_busy, r_done;
    logic [63:0]  r_pp;
    logic [1:0]   r_pp_sh;
    logic [127:0] r_acc;
    logic [31:0]  a_sel, b_sel;
    logic [127:0] pp_ext;

    // partial product select: cnt[0] picks a half, cnt[1] picks b half
    assign a_sel = r_cnt[0] ? r_a[63:32] : r_a[31:0];
    assign b_sel = r_cnt[1] ? r_b[63:32] : r_b[31:0];

    always_comb begin
        unique case (r_pp_sh)
            2'd0:    pp_ext = {64'd0, r_pp};
            2'd1:    pp_ext = {32'd0, r_pp, 32'd0};
            default: pp_ext = {r_pp, 64'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_cnt  <= 3'd0;
                r_acc  <= 128'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_cnt != 3'd4) begin
                    r_pp    <= 64'(a_sel) * 64'(b_sel);
                    r_pp_sh <= 2'(r_cnt[0]) + 2'(r_cnt[1]);
                end
                if (r_cnt != 3'd0) r_acc <= r_acc + pp_ext;
                if (r_cnt == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 3'd1;
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;
endmodule

>>> rtl/pgn_div.sv
// restoring divider: floor({hi,lo}/d), one quotient bit per cycle
module pgn_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_hi,
    input  logic [63:0] i_lo,
    input  logic [63:0] i_d,
    output logic        o_done,
    output logic [63:0] o_q
);
    logic [64:0] r_rem;
    logic [63:0] r_lo, r_q, r_d;
    logic [6:0]  r_cnt;
    logic        r_busy, r_done;
    logic [64:0] sh;
    logic        ge;

    assign sh = {r_rem[63:0], r_lo[63]};
    assign ge = sh >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= {1'b0, i_hi};
                r_lo   <= i_lo;
                r_d    <= i_d;
                r_q    <= 64'd0;
                r_cnt  <= 7'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= ge ? sh - {1'b0, r_d} : sh;
                r_lo  <= r_lo << 1;
                r_q   <= {r_q[62:0], ge};
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;
endmodule

>>> rtl/pgn_sqrt.sv
// integer square root, two radicand bits per cycle
module pgn_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_y,
    output logic        o_done,
    output logic [31:0] o_r
);
    logic [63:0] r_y, r_res;
    logic [4:0]  r_cnt;
    logic        r_busy, r_done;
    logic [63:0] bit_v, trial;

    assign bit_v = 64'd1 << (7'd62 - {r_cnt, 1'b0});
    assign trial = r_res + bit_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_y    <= i_y;
                r_res  <= 64'd0;
                r_cnt  <= 5'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_y >= trial) begin
                    r_y   <= r_y - trial;
                    r_res <= (r_res >> 1) + bit_v;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_r    = r_res[31:0];
endmodule

>>> rtl/pcg_polar_gaussian_noise.sv
// Gaussian noise source: PCG32 XSH-RR generator feeding a Marsaglia polar
// transform, its long arithmetic on one shared multiplier, divider and root unit.
// Input channel (valid/stall): a word with func 0 reseeds the stream from
// the tile coordinates and the base seed; func 1 draws one pair of uniforms.
// Output channel (valid/stall): one word of two Q5.26 normals per kept pair;
// a rejected pair gives no word. Config channel (valid/ready, always ready)
// writes the 64-bit base seed.
// A seed word takes two multiplies. A draw runs three serial divisions
// (z and the two samples) on the one divider, 33 multiplies (the twelve
// series divisions by odd constants are multiplies by their reciprocals),
// up to 61 normalize shifts and two roots. A rejected draw returns to idle
// from the normalize step.
// The input is stalled for the whole of an item.
// Reset clears the stream state and base seed to zero and empties the output.
// A finished pair waits in the output register while the receiver stalls;
// new items are taken meanwhile, and a later pair holds until it drains.
module pcg_polar_gaussian_noise (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  pgn_pkg::t_in     i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output pgn_pkg::t_out    o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [63:0]      i_cfg_data
);
    pgn_pkg::t_state r_state, n_state;
    pgn_pkg::t_in    r_in;
    logic [63:0]  r_base, r_st, r_h;
    logic         r_wait;
    logic         r_j;
    logic [1:0]   r_neg;
    logic [31:0]  r_m [2];
    logic [63:0]  r_msq [2];
    logic [63:0]  r_s, r_t, r_z, r_z2, r_p, r_acc, r_n57, r_y;
    logic [5:0]   r_k, r_e;
    logic [3:0]   r_i;
    logic [31:0]  r_q, r_smp0;
    logic         r_out_valid;
    pgn_pkg::t_out r_out;

    logic          mul_start, div_start, sqrt_start;
    logic [63:0]   mul_a, mul_b, div_hi, div_lo, div_d, sqrt_y;
    logic          mul_done, div_done, sqrt_done, unit_done;
    logic [127:0]  mul_p;
    logic [63:0]   div_q;
    logic [31:0]   sqrt_r;

    logic          in_acc, out_load;
    logic [63:0]   lcg_next, s_sum, pe, num, den, nln2, lnabs, n57, t64;
    logic [31:0]   u, mag, samp, qr;
    logic          uneg, reject;
    logic [5:0]    n_val;
    logic [37:0]   ph, pl;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != pgn_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign unit_done  = mul_done || div_done || sqrt_done;

    // datapath helpers
    assign lcg_next = mul_p[63:0] + pgn_pkg::LCG_INC;
    assign u        = pgn_pkg::pgn_perm(lcg_next);
    assign uneg     = u < pgn_pkg::HALF_M1;
    assign mag      = uneg ? pgn_pkg::HALF_M1 - u : u - pgn_pkg::HALF_M1;
    assign s_sum    = r_msq[0] + r_msq[1];
    assign reject   = (r_s == 64'd0) || (r_s[63:62] != 2'b00);
    assign pe       = 64'd1 << r_e;
    assign num      = (r_s >= pe) ? r_s - pe : pe - r_s;
    assign den      = r_s + pe;
    assign n_val    = 6'd62 - r_e;
    assign ph       = 38'(n_val) * 38'(pgn_pkg::LN2_HI);
    assign pl       = 38'(n_val) * 38'(pgn_pkg::LN2_LO);
    assign t64      = {26'd0, ph};
    assign nln2     = (t64 << 25) + 64'(pl >> 7);
    assign lnabs    = (r_acc + 64'd8) >> 4;
    assign n57      = (r_s < pe) ? nln2 + lnabs : ((nln2 > lnabs) ? nln2 - lnabs : 64'd0);
    assign qr       = r_q + 32'((r_y >= mul_p[63:0]) ? 1 : 0);
    assign samp     = r_neg[r_j] ? 32'd0 - qr : qr;
    assign out_load = (r_state == pgn_pkg::S_OUT) && (!r_out_valid || !i_out_stall);

    // sequencer: next state and unit requests
    always_comb begin
        n_state    = r_state;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        mul_a      = r_z;
        mul_b      = r_z;
        div_hi     = 64'd0;
        div_lo     = 64'd0;
        div_d      = r_s;
        sqrt_y     = r_y;
        unique case (r_state)
            pgn_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_in_data.func == pgn_pkg::FUNC_SEED) ?
                              pgn_pkg::S_SEED1 : pgn_pkg::S_LCG;
                end
            end
            pgn_pkg::S_SEED1: begin
                mul_a = r_base;
                mul_b = pgn_pkg::GOLD;
                mul_start = !r_wait;
                if (r_wait && unit_done) n_state = pgn_pkg::S_SEED2;
            end
            pgn_pkg::S_SEED2: begin
                mul_a = r_h;
                mul_b = pgn_pkg::GOLD;
                mul_start = !r_wait;
                if (r_wait && unit_done) n_state = pgn_pkg::S_IDLE;
            end
            pgn_pkg::S_LCG: begin
                mul_a = r_st;
                mul_b = pgn_pkg::LCG_MULT;
                mul_start = !r_wait;
                if (r_wait && unit_done && r_j) n_state = pgn_pkg::S_SQ;
            end
            pgn_pkg::S_SQ: begin
                mul_a = 64'(r_m[r_j]);
                mul_b = 64'(r_m[r_j]);
                mul_start = !r_wait;
                if (r_wait && unit_done && r_j) n_state = pgn_pkg::S_CHECK;
            end
            pgn_pkg::S_CHECK: n_state = pgn_pkg::S_NORM;
            pgn_pkg::S_NORM: begin
                if (reject) n_state = pgn_pkg::S_IDLE;
                else if (r_t[pgn_pkg::TOP_BIT]) n_state = pgn_pkg::S_ZDIV;
            end
            pgn_pkg::S_ZDIV: begin
                div_hi = num >> 2;
                div_lo = {num[1:0], 62'd0};
                div_d  = den;
                div_start = !r_wait;
                if (r_wait && unit_done) n_state = pgn_pkg::S_Z2;
            end
            pgn_pkg::S_Z2: begin
                mul_start = !r_wait;
                if (r_wait && unit_done) n_state = pgn_pkg::S_PMUL;
            end
            pgn_pkg::S_PMUL: begin
                mul_a = r_p;
                mul_b = r_z2;
                mul_start = !r_wait;
                if (r_wait && unit_done) n_state = pgn_pkg::S_PDIV;
            end
            pgn_pkg::S_PDIV: begin
                // term over its odd divisor, by reciprocal multiply
                mul_a = r_p;
                mul_b = pgn_pkg::pgn_recip(r_i);
                mul_start = !r_wait;
                if (r_wait && unit_done) begin
                    n_state = (r_i == pgn_pkg::N_TERMS) ? pgn_pkg::S_LN : pgn_pkg::S_PMUL;
                end
            end
            pgn_pkg::S_LN: n_state = pgn_pkg::S_YMUL;
            pgn_pkg::S_YMUL: begin
                mul_a = r_n57;
                mul_b = r_msq[r_j];
                mul_start = !r_wait;
                if (r_wait && unit_done) n_state = pgn_pkg::S_YDIV;
            end
            pgn_pkg::S_YDIV: begin
                div_hi = mul_p[127:64];
                div_lo = mul_p[63:0];
                div_d  = r_s;
                div_start = !r_wait;
                if (r_wait && unit_done) n_state = pgn_pkg::S_SQRT;
            end
            pgn_pkg::S_SQRT: begin
                sqrt_start = !r_wait;
                if (r_wait && unit_done) n_state = pgn_pkg::S_GMUL;
            end
            pgn_pkg::S_GMUL: begin
                mul_a = {30'd0, r_q, 2'b10};
                mul_b = {30'd0, r_q, 2'b10};
                mul_start = !r_wait;
                if (r_wait && unit_done) begin
                    n_state = r_j ? pgn_pkg::S_OUT : pgn_pkg::S_YMUL;
                end
            end
            pgn_pkg::S_OUT: if (out_load) n_state = pgn_pkg::S_IDLE;
            default: n_state = pgn_pkg::S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pgn_pkg::S_IDLE;
            r_wait      <= 1'b0;
            r_out_valid <= 1'b0;
            r_base      <= 64'd0;
            r_st        <= 64'd0;
        end else begin
            r_state <= n_state;
            if (mul_start || div_start || sqrt_start) r_wait <= 1'b1;
            else if (unit_done) r_wait <= 1'b0;
            if (out_load) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
            if (i_cfg_valid) r_base <= i_cfg_data;
            if (r_wait && unit_done) begin
                if (r_state == pgn_pkg::S_SEED2) begin
                    r_st <= mul_p[63:0] + 64'(unsigned'(r_in.tile_col));
                end else if (r_state == pgn_pkg::S_LCG) begin
                    r_st <= lcg_next;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_data;
            r_j  <= 1'b0;
        end
        if (out_load) r_out <= '{sample_first: r_smp0, sample_second: r_q};
        unique case (r_state)
            pgn_pkg::S_SEED1: begin
                if (r_wait && unit_done) begin
                    r_h <= mul_p[63:0] + 64'(unsigned'(r_in.tile_row));
                end
            end
            pgn_pkg::S_LCG, pgn_pkg::S_SQ: begin
                if (r_wait && unit_done) begin
                    if (r_state == pgn_pkg::S_LCG) begin
                        r_neg[r_j] <= uneg;
                        r_m[r_j]   <= mag;
                    end else begin
                        r_msq[r_j] <= mul_p[63:0];
                    end
                    r_j <= !r_j;
                end
            end
            pgn_pkg::S_CHECK: begin
                r_s <= s_sum;
                r_t <= s_sum;
                r_k <= pgn_pkg::TOP_BIT;
            end
            pgn_pkg::S_NORM: begin
                // shift until the leading one sits at the top bit
                if (!r_t[pgn_pkg::TOP_BIT]) begin
                    r_t <= r_t << 1;
                    r_k <= r_k - 6'd1;
                end else begin
                    r_e <= (r_t >= pgn_pkg::SQRT2_Q61) ? r_k + 6'd1 : r_k;
                end
            end
            pgn_pkg::S_ZDIV: if (r_wait && unit_done) r_z <= div_q;
            pgn_pkg::S_Z2: begin
                if (r_wait && unit_done) begin
                    r_z2  <= mul_p[125:62];
                    r_p   <= r_z;
                    r_acc <= r_z;
                    r_i   <= 4'd1;
                end
            end
            pgn_pkg::S_PMUL: if (r_wait && unit_done) r_p <= mul_p[125:62];
            pgn_pkg::S_PDIV: begin
                if (r_wait && unit_done) begin
                    r_acc <= r_acc + {1'b0, mul_p[127:65]};
                    r_i   <= r_i + 4'd1;
                end
            end
            pgn_pkg::S_LN: begin
                r_n57 <= n57;
                r_j   <= 1'b0;
            end
            pgn_pkg::S_YDIV: if (r_wait && unit_done) r_y <= div_q;
            pgn_pkg::S_SQRT: if (r_wait && unit_done) r_q <= {2'b00, sqrt_r[31:2]};
            pgn_pkg::S_GMUL: begin
                // round-to-nearest correction, then sign
                if (r_wait && unit_done) begin
                    if (!r_j) r_smp0 <= samp;
                    else      r_q    <= samp;
                    r_j <= !r_j;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    pgn_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    pgn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_hi    (div_hi),
        .i_lo    (div_lo),
        .i_d     (div_d),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    pgn_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_y     (sqrt_y),
        .o_done  (sqrt_done),
        .o_r     (sqrt_r)
    );
endmodule

>>> rtl/pgn_checker.sv
module pgn_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input pgn_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input pgn_pkg::t_out o_out_data,
    input logic          i_cfg_valid,
    input logic          o_cfg_ready,
    input logic [63:0]   i_cfg_data
);
    // an accepted word keeps the input closed for the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input open right after an accepted word");

    // a new result appears only while an item is in work
    a_out_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("output word without an item in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output valid dropped under stall");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_data))
        else $error("output word changed under stall");
endmodule

bind pcg_polar_gaussian_noise pgn_checker u_pgn_checker (.*);
